// ===== hw/rtl/lipr_pkg.sv =====
// shared types and constants for the linear interpolation pcm resampler
// no dependencies; used by every module under hw/rtl
package lipr_pkg;

  localparam int IN_W        = 32;
  localparam int SAMPLE_W    = 16;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int CONV_SHIFT  = 13;
  localparam int STEP_W      = 18;
  localparam int MAX_RUN     = 8;
  localparam int RUN_CNT_W   = $clog2(MAX_RUN);
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 1'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 18'd65536;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // one classified input item: previous pair and the step to the current pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev_l;
    logic signed [SAMPLE_W-1:0] prev_r;
    logic signed [DIFF_W-1:0]   diff_l;
    logic signed [DIFF_W-1:0]   diff_r;
  } entry_t;

  // arithmetic shift toward minus infinity, then saturate to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] conv_sample(
      input logic signed [IN_W-1:0] s);
    logic signed [IN_W-CONV_SHIFT-1:0] sh;
    logic signed [SAMPLE_W-1:0]        r;
    sh = (IN_W-CONV_SHIFT)'(s >>> CONV_SHIFT);
    if (sh > (IN_W-CONV_SHIFT)'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else if (sh < (IN_W-CONV_SHIFT)'(SAMPLE_MIN)) begin
      r = SAMPLE_MIN;
    end else begin
      r = sh[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lipr_front.sv =====
// front end: accepts sample pairs, converts them to 16 bits, keeps the previous pair
// depends on lipr_pkg
module lipr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           stereo_mode,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [lipr_pkg::IN_W-1:0] left_sample,
  input  logic signed [lipr_pkg::IN_W-1:0] right_sample,
  output logic                           push,
  input  logic                           q_full,
  output lipr_pkg::entry_t               push_data
);

  logic signed [lipr_pkg::SAMPLE_W-1:0] prev_l;
  logic signed [lipr_pkg::SAMPLE_W-1:0] prev_r;
  logic signed [lipr_pkg::SAMPLE_W-1:0] cur_l;
  logic signed [lipr_pkg::SAMPLE_W-1:0] cur_r;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign cur_l = lipr_pkg::conv_sample(left_sample);
  assign cur_r = lipr_pkg::conv_sample(right_sample);

  always_comb begin
    push_data.prev_l = prev_l;
    push_data.prev_r = prev_r;
    push_data.diff_l = {cur_l[lipr_pkg::SAMPLE_W-1], cur_l}
                     - {prev_l[lipr_pkg::SAMPLE_W-1], prev_l};
    push_data.diff_r = {cur_r[lipr_pkg::SAMPLE_W-1], cur_r}
                     - {prev_r[lipr_pkg::SAMPLE_W-1], prev_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_l <= '0;
      prev_r <= '0;
    end else if (push) begin
      prev_l <= cur_l;
      if (stereo_mode) begin
        prev_r <= cur_r;
      end
    end
  end

endmodule

// ===== hw/rtl/lipr_queue.sv =====
// short queue of classified items between front and back
// depends on lipr_pkg
module lipr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lipr_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output lipr_pkg::entry_t q_data
);

  localparam int PTR_W = $clog2(lipr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lipr_pkg::QUEUE_DEPTH + 1);

  lipr_pkg::entry_t mem [lipr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(lipr_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(lipr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(lipr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("queue read while empty");

endmodule

// ===== hw/rtl/lipr_back.sv =====
// back end: phase sequencer, multiply stage and output register
// depends on lipr_pkg
module lipr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lipr_pkg::STEP_W-1:0]         phase_step,
  input  logic                                stereo_mode,
  input  logic                                q_valid,
  input  lipr_pkg::entry_t                    q_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lipr_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [lipr_pkg::SAMPLE_W-1:0] out_right,
  output logic                                out_last
);

  localparam int PH_W   = ((FRAC_BITS + 1 > lipr_pkg::STEP_W) ?
                           FRAC_BITS + 1 : lipr_pkg::STEP_W) + 1;
  localparam int PROD_W = lipr_pkg::DIFF_W + FRAC_BITS + 1;
  localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC_BITS;

  logic                             busy;
  lipr_pkg::entry_t                 cur;
  logic [PH_W-1:0]                  ph;
  logic [lipr_pkg::RUN_CNT_W-1:0]   n;

  logic                             en;
  logic                             issue;
  logic                             last_issue;
  logic                             finishing;
  logic [PH_W-1:0]                  ph_step;
  logic [PH_W-1:0]                  finish_phase;
  logic [PH_W-1:0]                  ph_base;
  logic signed [FRAC_BITS:0]        frac;

  logic                             s1_valid;
  logic                             s1_last;
  logic signed [PROD_W-1:0]         s1_prod_l;
  logic signed [PROD_W-1:0]         s1_prod_r;
  logic signed [lipr_pkg::SAMPLE_W-1:0] s1_prev_l;
  logic signed [lipr_pkg::SAMPLE_W-1:0] s1_prev_r;
  logic signed [lipr_pkg::SAMPLE_W-1:0] res_l;
  logic signed [lipr_pkg::SAMPLE_W-1:0] res_r;

  assign en           = !out_valid || out_ready;
  assign issue        = busy && en;
  assign ph_step      = ph + PH_W'(phase_step);
  assign last_issue   = (ph_step >= ONE) || (n == lipr_pkg::RUN_CNT_W'(lipr_pkg::MAX_RUN - 1));
  assign finishing    = issue && last_issue;
  assign finish_phase = (ph_step >= ONE) ? ph_step - ONE : '0;
  assign ph_base      = finishing ? finish_phase : ph;
  assign pop          = q_valid && (!busy || finishing);
  assign frac         = {1'b0, ph[FRAC_BITS-1:0]};

  // phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= '0;
      n    <= '0;
    end else if (pop) begin
      if (ph_base >= ONE) begin
        busy <= 1'b0;
        ph   <= ph_base - ONE;
      end else begin
        busy <= 1'b1;
        ph   <= ph_base;
        n    <= '0;
      end
    end else if (finishing) begin
      busy <= 1'b0;
      ph   <= finish_phase;
    end else if (issue) begin
      ph <= ph_step;
      n  <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last   <= last_issue;
      s1_prod_l <= PROD_W'(cur.diff_l * frac);
      s1_prod_r <= PROD_W'(cur.diff_r * frac);
      s1_prev_l <= cur.prev_l;
      s1_prev_r <= cur.prev_r;
    end
  end

  // floor shift, then add; the sum always fits 16 bits
  assign res_l = s1_prev_l + s1_prod_l[FRAC_BITS +: lipr_pkg::SAMPLE_W];
  assign res_r = stereo_mode ? s1_prev_r + s1_prod_r[FRAC_BITS +: lipr_pkg::SAMPLE_W]
                             : res_l;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_left  <= res_l;
      out_right <= res_r;
      out_last  <= s1_last;
    end
  end

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst) busy |-> ph < ONE)
    else $error("sequencer running with phase at or above one");
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
      issue && n == lipr_pkg::RUN_CNT_W'(lipr_pkg::MAX_RUN - 1) |-> finishing)
    else $error("run exceeded the result limit");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !en |=> s1_valid && $stable(s1_prod_l) && $stable(s1_last))
    else $error("multiply stage lost a result under stall");

endmodule

// ===== hw/rtl/linear_interp_pcm_resampler_unit.sv =====
// top level of the linear interpolation pcm resampler
// depends on lipr_pkg, lipr_front, lipr_queue, lipr_back
//
// usage:
//   s_* carries one decoded sample pair per beat (signed, 28 fraction bits).
//   m_* carries interpolated 16-bit pairs; m_tlast marks the final beat
//   caused by one input beat. An input whose phase is already at or above one
//   causes no output beat.
//   cfg_* writes phase_step (index 0) and stereo_mode (index 1); write only
//   while no input is in flight. cfg_ready is always high.
// timing:
//   an input beat causes n outputs (0..8); the phase sequencer issues one output
//   per cycle while m_tready does not stall the back end.
//   an input beat goes through the queue, sequencer, multiply stage and output
//   register; a 4-entry queue lets the front keep accepting during long runs.
// reset:
//   clears the previous pair and the phase, sets phase_step to 1.0 and stereo.
// stall:
//   a low m_tready freezes the multiply stage and output register; the queue
//   then fills and s_tready drops.
module linear_interp_pcm_resampler_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [2*lipr_pkg::IN_W-1:0]          s_tdata,   // left_sample, right_sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [2*lipr_pkg::SAMPLE_W-1:0]      m_tdata,   // out_left, out_right
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lipr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lipr_pkg::STEP_W-1:0]          cfg_data
);

  logic [lipr_pkg::STEP_W-1:0] phase_step;
  logic                        stereo_mode;

  logic                        push;
  logic                        q_full;
  lipr_pkg::entry_t            push_data;
  logic                        pop;
  logic                        q_valid;
  lipr_pkg::entry_t            q_data;

  logic signed [lipr_pkg::SAMPLE_W-1:0] out_left;
  logic signed [lipr_pkg::SAMPLE_W-1:0] out_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= lipr_pkg::STEP_RESET;
      stereo_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lipr_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data;
        lipr_pkg::REG_STEREO_MODE: stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lipr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .stereo_mode  (stereo_mode),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .left_sample  (s_tdata[lipr_pkg::IN_W-1:0]),
    .right_sample (s_tdata[2*lipr_pkg::IN_W-1:lipr_pkg::IN_W]),
    .push         (push),
    .q_full       (q_full),
    .push_data    (push_data)
  );

  lipr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  lipr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_step  (phase_step),
    .stereo_mode (stereo_mode),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_left    (out_left),
    .out_right   (out_right),
    .out_last    (m_tlast)
  );

  assign m_tdata = {out_right, out_left};

endmodule

// ===== tb/sv/linear_interp_pcm_resampler_unit_tb.sv =====
// self-checking testbench for linear_interp_pcm_resampler_unit
// depends on lipr_pkg and the resampler rtl; a scoreboard class predicts the
// interpolated output beats of each input pair and checks them in order
module linear_interp_pcm_resampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC            = 16;
  localparam int unsigned PHASE_ONE       = 1 << FRAC;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          RANDOM_PHASES   = 6;
  localparam int          ITEMS_PER_PHASE = 22;
  localparam int          HOLD_CYCLES     = 300;

  typedef struct {
    logic signed [lipr_pkg::SAMPLE_W-1:0] left;
    logic signed [lipr_pkg::SAMPLE_W-1:0] right;
    logic                                 last;
  } pcm_beat_t;

  class resample_scoreboard;
    logic signed [lipr_pkg::SAMPLE_W-1:0] hist_l;
    logic signed [lipr_pkg::SAMPLE_W-1:0] hist_r;
    int unsigned                          phase;
    logic [lipr_pkg::STEP_W-1:0]          step;
    bit                                   stereo;
    pcm_beat_t                            expected_q[$];
    int                                   errors;

    function new();
      hist_l = '0;
      hist_r = '0;
      phase  = 0;
      step   = lipr_pkg::STEP_RESET;
      stereo = 1'b1;
      errors = 0;
    endfunction

    function void write_reg(logic [lipr_pkg::CFG_IDX_W-1:0] idx,
                            logic [lipr_pkg::STEP_W-1:0] val);
      if (idx == lipr_pkg::REG_PHASE_STEP) begin
        step = val;
      end else if (idx == lipr_pkg::REG_STEREO_MODE) begin
        stereo = val[0];
      end
    endfunction

    function logic signed [lipr_pkg::SAMPLE_W-1:0] to_pcm16(
        logic signed [lipr_pkg::IN_W-1:0] raw);
      logic signed [lipr_pkg::IN_W-1:0] sh;
      sh = raw >>> lipr_pkg::CONV_SHIFT;
      if (sh > 32767) begin
        return lipr_pkg::SAMPLE_MAX;
      end else if (sh < -32768) begin
        return lipr_pkg::SAMPLE_MIN;
      end
      return sh[lipr_pkg::SAMPLE_W-1:0];
    endfunction

    function logic signed [lipr_pkg::SAMPLE_W-1:0] lerp(
        logic signed [lipr_pkg::SAMPLE_W-1:0] a,
        logic signed [lipr_pkg::SAMPLE_W-1:0] b,
        int unsigned frac);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(frac);
      return lipr_pkg::SAMPLE_W'(longint'(a) + (prod >>> FRAC));
    endfunction

    function void note_input(logic [lipr_pkg::IN_W-1:0] raw_l,
                             logic [lipr_pkg::IN_W-1:0] raw_r);
      logic signed [lipr_pkg::SAMPLE_W-1:0] cur_l;
      logic signed [lipr_pkg::SAMPLE_W-1:0] cur_r;
      int unsigned                          ph;
      int                                   n;
      pcm_beat_t                            b;
      cur_l = to_pcm16(raw_l);
      cur_r = stereo ? to_pcm16(raw_r) : '0;
      ph = phase;
      n = 0;
      while (ph < PHASE_ONE && n < lipr_pkg::MAX_RUN) begin
        b.left  = lerp(hist_l, cur_l, ph);
        b.right = stereo ? lerp(hist_r, cur_r, ph) : b.left;
        ph += step;
        n++;
        b.last = (ph >= PHASE_ONE) || (n == lipr_pkg::MAX_RUN);
        expected_q.push_back(b);
      end
      // a run cut short at eight beats leaves the phase at zero
      phase = (ph >= PHASE_ONE) ? ph - PHASE_ONE : 0;
      hist_l = cur_l;
      if (stereo) begin
        hist_r = cur_r;
      end
    endfunction

    function void check_beat(logic signed [lipr_pkg::SAMPLE_W-1:0] l,
                             logic signed [lipr_pkg::SAMPLE_W-1:0] r,
                             logic last);
      pcm_beat_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: left %0d right %0d last %0b",
                 $time, l, r, last);
      end else begin
        e = expected_q.pop_front();
        if (l !== e.left) begin
          errors++;
          $display("%0t out_left expected %0d actual %0d", $time, e.left, l);
        end
        if (r !== e.right) begin
          errors++;
          $display("%0t out_right expected %0d actual %0d", $time, e.right, r);
        end
        if (last !== e.last) begin
          errors++;
          $display("%0t last_of_run expected %0b actual %0b", $time, e.last, last);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  logic [2*lipr_pkg::IN_W-1:0]         s_tdata   = '0;   // left_sample, right_sample
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  logic [2*lipr_pkg::SAMPLE_W-1:0]     m_tdata;          // out_left, out_right
  logic                                m_tlast;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [lipr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [lipr_pkg::STEP_W-1:0]         cfg_data  = '0;

  int src_idle  = 0;
  int sink_idle = 0;
  int hold_req  = 0;

  resample_scoreboard sb = new();

  linear_interp_pcm_resampler_unit #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_beat(m_tdata[lipr_pkg::SAMPLE_W-1:0],
                      m_tdata[2*lipr_pkg::SAMPLE_W-1:lipr_pkg::SAMPLE_W], m_tlast);
      end
      if (s_tvalid && s_tready) begin
        sb.note_input(s_tdata[lipr_pkg::IN_W-1:0],
                      s_tdata[2*lipr_pkg::IN_W-1:lipr_pkg::IN_W]);
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_pair(logic [lipr_pkg::IN_W-1:0] l, logic [lipr_pkg::IN_W-1:0] r);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(logic [lipr_pkg::STEP_W-1:0] step, logic stereo);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= lipr_pkg::REG_PHASE_STEP;
    cfg_data  <= step;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= lipr_pkg::REG_STEREO_MODE;
    cfg_data  <= lipr_pkg::STEP_W'(stereo);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [lipr_pkg::IN_W-1:0] pick_sample();
    logic [lipr_pkg::IN_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        // in range: top bits follow the sign of the 16-bit value
        v = $urandom;
        v[lipr_pkg::IN_W-1:lipr_pkg::CONV_SHIFT+lipr_pkg::SAMPLE_W-1] =
          {(lipr_pkg::IN_W-lipr_pkg::CONV_SHIFT-lipr_pkg::SAMPLE_W+1)
            {v[lipr_pkg::CONV_SHIFT+lipr_pkg::SAMPLE_W-1]}};
      end
      8: begin
        v = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      end
      9: begin
        // around the saturation thresholds
        v = $urandom_range(1) ? 32'h10000000 : 32'hf0000000;
        v = v + $urandom_range(32'h3fff) - 32'h2000;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic logic [lipr_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(7))
      0:       return lipr_pkg::STEP_W'($urandom_range(8191));
      1:       return lipr_pkg::STEP_W'($urandom_range(2**lipr_pkg::STEP_W-1, 131073));
      default: return lipr_pkg::STEP_W'($urandom_range(131072, 8192));
    endcase
  endfunction

  initial begin
    int p;
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: unit step, stereo, saturation edges
    send_pair(32'h7fffffff, 32'h80000000);
    send_pair(32'h80000000, 32'h7fffffff);
    send_pair(32'h00000000, 32'hffffffff);
    send_pair(32'h0fffffff, 32'hf0000000);
    send_pair(32'h10000000, 32'hefffffff);
    send_pair(32'h0fffe000, 32'hf0001fff);

    // half step, full-scale swings
    apply_setting(18'd32768, 1'b1);
    send_pair(32'h7fffffff, 32'h80000000);
    send_pair(32'h80000000, 32'h7fffffff);
    send_pair(32'h00002000, 32'hffffe000);

    // zero step: run capped at eight beats
    apply_setting(18'd0, 1'b1);
    send_pair(32'h0abcdef0, 32'hf1234567);
    send_pair(32'hf5432100, 32'h0edcba98);

    // largest step: phase runs above one, so some inputs give no output
    apply_setting(18'h3ffff, 1'b1);
    send_pair(32'h01000000, 32'hff000000);
    send_pair(32'h02000000, 32'hfe000000);
    send_pair(32'h03000000, 32'hfd000000);
    send_pair(32'h04000000, 32'hfc000000);

    // mono, step just below the eight-beat limit
    apply_setting(18'd8191, 1'b0);
    send_pair(32'h0fffffff, 32'h55555555);
    send_pair(32'hf0000000, 32'haaaaaaaa);

    apply_setting(18'd8192, 1'b0);
    send_pair(32'h7fffffff, 32'h12345678);
    send_pair(32'h80000000, 32'h87654321);

    apply_setting(18'd131072, 1'b1);
    send_pair(32'h05555000, 32'hfaaab000);
    send_pair(32'hfaaab000, 32'h05555000);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       apply_setting(lipr_pkg::STEP_RESET, 1'b1);
        1:       apply_setting(18'd8192, 1'b0);
        2:       apply_setting(pick_step(), 1'b1);
        3:       apply_setting(18'd131072, 1'b1);
        4:       apply_setting(pick_step(), 1'($urandom_range(1)));
        default: apply_setting(pick_step(), 1'b1);
      endcase
      src_idle  = (p % 4 == 1) ? 70 : (p % 4 == 3) ? 6 : 0;
      sink_idle = (p % 4 == 2) ? 70 : (p % 4 == 3) ? 6 : 0;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 2 && k == 0) begin
          hold_req = HOLD_CYCLES;
        end
        if (p == 3 && k == ITEMS_PER_PHASE / 2) begin
          drain();
        end
        send_pair(pick_sample(), pick_sample());
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== linear_interp_pcm_resampler_unit.f =====
hw/rtl/lipr_pkg.sv
hw/rtl/lipr_front.sv
hw/rtl/lipr_queue.sv
hw/rtl/lipr_back.sv
hw/rtl/linear_interp_pcm_resampler_unit.sv
tb/sv/linear_interp_pcm_resampler_unit_tb.sv
